// File: hdl/tgadec_pkg.sv
// Types and constants shared by the TGA run-length image decoder.
`default_nettype none
package tgadec_pkg;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SIG,
      PH_DIMS,
      PH_PKT,
      PH_PIX
   } phase_type;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BAD_SIG  = 2'd1;
   localparam logic [1:0] ST_BAD_SIZE = 2'd2;
   localparam logic [1:0] ST_CLIPPED  = 2'd3;

   localparam logic [7:0] TYPE_RAW = 8'd2;
   localparam logic [7:0] TYPE_RLE = 8'd10;
   localparam logic [7:0] DEPTH_24 = 8'd24;
   localparam logic [7:0] DEPTH_32 = 8'd32;
   localparam logic [7:0] RUN_BIAS = 8'd127;

   localparam logic [4:0] HDR_TYPE      = 5'd2;
   localparam logic [4:0] HDR_SIG_LAST  = 5'd11;
   localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
   localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
   localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
   localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
   localparam logic [4:0] HDR_DEPTH     = 5'd16;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       has_alpha;
      logic [7:0] repeat_count;
      logic       image_done;
      logic [1:0] status;
   } rsp_type;

endpackage
`default_nettype wire

// File: hdl/tgadec_if.sv
// Valid/ready channel interfaces for file bytes in and pixel records out.
`default_nettype none
interface tgadec_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       file_start;

   modport source (output valid, output byte_value, output file_start, input ready);
   modport sink (input valid, input byte_value, input file_start, output ready);
endinterface

interface tgadec_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [7:0] alpha;
   logic       has_alpha;
   logic [7:0] repeat_count;
   logic       image_done;
   logic [1:0] status;

   modport source (output valid, output red, output green, output blue, output alpha,
                   output has_alpha, output repeat_count, output image_done,
                   output status, input ready);
   modport sink (input valid, input red, input green, input blue, input alpha,
                 input has_alpha, input repeat_count, input image_done,
                 input status, output ready);
endinterface
`default_nettype wire

// File: hdl/tgadec_core.sv
// Parser state and per-byte decode: header check, packet tracking, pixel assembly.
`default_nettype none
module tgadec_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire logic [7:0]       byte_value,
   input  wire logic             file_start,
   output logic                  res_valid,
   output tgadec_pkg::rsp_type   res
);

   tgadec_pkg::phase_type phase_ff, phase_in, phase_cur;
   logic [4:0]  hdr_ff, hdr_in, hdr_cur;
   logic        compressed_ff, compressed_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic        four_ff, four_in;
   logic [31:0] left_ff, left_in;
   logic [7:0]  pkt_ff, pkt_in;
   logic        is_run_ff, is_run_in;
   logic [1:0]  pbi_ff, pbi_in;
   logic [31:0] colour_ff, colour_in;

   logic [1:0]  pbi_next;
   logic        pixel_end;
   logic [31:0] left_dec;
   logic [7:0]  pkt_dec;
   logic        run_clip;
   logic [7:0]  run_rep;
   logic [31:0] run_left;
   logic        sig_bad;
   logic        size_bad;
   logic        pix_done;

   always_comb begin
      phase_cur = file_start ? tgadec_pkg::PH_SIG : phase_ff;
      hdr_cur   = file_start ? 5'd0 : hdr_ff;
   end

   always_comb begin
      pbi_next  = pbi_ff + 2'd1;
      pixel_end = (pbi_next == 2'd0) || (!four_ff && (pbi_next == 2'd3));
      left_dec  = left_ff - 32'd1;
      pkt_dec   = pkt_ff - 8'd1;
      run_clip  = {24'd0, pkt_ff} > left_ff;
      run_rep   = run_clip ? left_ff[7:0] : pkt_ff;
      run_left  = left_ff - {24'd0, run_rep};
      sig_bad   = (hdr_cur == tgadec_pkg::HDR_TYPE)
                  ? (byte_value != tgadec_pkg::TYPE_RAW && byte_value != tgadec_pkg::TYPE_RLE)
                  : (byte_value != 8'd0);
      size_bad  = (width_ff == 16'd0) || (height_ff == 16'd0) ||
                  (byte_value != tgadec_pkg::DEPTH_24 && byte_value != tgadec_pkg::DEPTH_32);
      if (!compressed_ff) begin
         pix_done = (left_dec == 32'd0);
      end else if (is_run_ff) begin
         pix_done = (run_left == 32'd0);
      end else begin
         pix_done = (left_dec == 32'd0);
      end
   end

   // next phase
   always_comb begin
      phase_in = phase_cur;
      unique case (phase_cur)
         tgadec_pkg::PH_IDLE: phase_in = tgadec_pkg::PH_IDLE;
         tgadec_pkg::PH_SIG: begin
            if (sig_bad) begin
               phase_in = tgadec_pkg::PH_IDLE;
            end else if (hdr_cur == tgadec_pkg::HDR_SIG_LAST) begin
               phase_in = tgadec_pkg::PH_DIMS;
            end
         end
         tgadec_pkg::PH_DIMS: begin
            if (hdr_cur == tgadec_pkg::HDR_DEPTH) begin
               if (size_bad) begin
                  phase_in = tgadec_pkg::PH_IDLE;
               end
            end else if (hdr_cur > tgadec_pkg::HDR_DEPTH) begin
               phase_in = compressed_ff ? tgadec_pkg::PH_PKT : tgadec_pkg::PH_PIX;
            end
         end
         tgadec_pkg::PH_PKT: phase_in = tgadec_pkg::PH_PIX;
         tgadec_pkg::PH_PIX: begin
            if (pixel_end) begin
               if (pix_done) begin
                  phase_in = tgadec_pkg::PH_IDLE;
               end else if (compressed_ff && (is_run_ff || pkt_dec == 8'd0)) begin
                  phase_in = tgadec_pkg::PH_PKT;
               end
            end
         end
         default: phase_in = tgadec_pkg::PH_IDLE;
      endcase
   end

   // datapath and result
   always_comb begin
      hdr_in        = hdr_cur;
      compressed_in = compressed_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      four_in       = four_ff;
      left_in       = left_ff;
      pkt_in        = pkt_ff;
      is_run_in     = is_run_ff;
      pbi_in        = pbi_ff;
      colour_in     = colour_ff;
      res_valid     = 1'b0;
      res           = '0;
      unique case (phase_cur)
         tgadec_pkg::PH_IDLE: ;
         tgadec_pkg::PH_SIG: begin
            if (sig_bad) begin
               res_valid  = 1'b1;
               res.status = tgadec_pkg::ST_BAD_SIG;
            end else begin
               hdr_in = hdr_cur + 5'd1;
               if (hdr_cur == tgadec_pkg::HDR_TYPE) begin
                  compressed_in = (byte_value == tgadec_pkg::TYPE_RLE);
               end
            end
         end
         tgadec_pkg::PH_DIMS: begin
            unique case (hdr_cur)
               tgadec_pkg::HDR_WIDTH_LO:  width_in[7:0]   = byte_value;
               tgadec_pkg::HDR_WIDTH_HI:  width_in[15:8]  = byte_value;
               tgadec_pkg::HDR_HEIGHT_LO: height_in[7:0]  = byte_value;
               tgadec_pkg::HDR_HEIGHT_HI: height_in[15:8] = byte_value;
               tgadec_pkg::HDR_DEPTH: begin
                  if (size_bad) begin
                     res_valid  = 1'b1;
                     res.status = tgadec_pkg::ST_BAD_SIZE;
                  end
                  four_in = (byte_value == tgadec_pkg::DEPTH_32);
               end
               default: begin
                  left_in   = {16'd0, width_ff} * {16'd0, height_ff};
                  pbi_in    = 2'd0;
                  is_run_in = 1'b0;
                  pkt_in    = 8'd0;
               end
            endcase
            if (hdr_cur <= tgadec_pkg::HDR_DEPTH) begin
               hdr_in = hdr_cur + 5'd1;
            end
         end
         tgadec_pkg::PH_PKT: begin
            is_run_in = byte_value[7];
            pkt_in    = byte_value[7] ? (byte_value - tgadec_pkg::RUN_BIAS)
                                      : (byte_value + 8'd1);
            pbi_in    = 2'd0;
         end
         tgadec_pkg::PH_PIX: begin
            colour_in[{pbi_ff, 3'b000} +: 8] = byte_value;
            pbi_in = pbi_next;
            if (pixel_end) begin
               pbi_in           = 2'd0;
               res_valid        = 1'b1;
               res.red          = colour_in[23:16];
               res.green        = colour_in[15:8];
               res.blue         = colour_in[7:0];
               res.alpha        = four_ff ? colour_in[31:24] : 8'd0;
               res.has_alpha    = four_ff;
               res.repeat_count = 8'd1;
               res.image_done   = pix_done;
               res.status       = tgadec_pkg::ST_OK;
               if (!compressed_ff) begin
                  left_in = left_dec;
               end else if (is_run_ff) begin
                  left_in          = run_left;
                  pkt_in           = 8'd0;
                  res.repeat_count = run_rep;
                  if (run_clip) begin
                     res.status = tgadec_pkg::ST_CLIPPED;
                  end
               end else begin
                  left_in = left_dec;
                  pkt_in  = pkt_dec;
                  if (pix_done && pkt_dec != 8'd0) begin
                     res.status = tgadec_pkg::ST_CLIPPED;
                  end
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= tgadec_pkg::PH_IDLE;
         hdr_ff   <= 5'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         hdr_ff   <= hdr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         compressed_ff <= compressed_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         four_ff       <= four_in;
         left_ff       <= left_in;
         pkt_ff        <= pkt_in;
         is_run_ff     <= is_run_in;
         pbi_ff        <= pbi_in;
         colour_ff     <= colour_in;
      end
   end

endmodule
`default_nettype wire

// File: hdl/tga_rle_image_decoder.sv
// Top level of the TGA image decoder: byte intake, decode core and result register.
// The decoder takes one file byte per clock and updates its parser state in that
// same cycle; a pixel record or status result appears in the result register on
// the following cycle. The result register is the only buffer, so a byte is taken
// every cycle while results drain, and intake pauses only while a result is held
// by the sink. A file begins at a byte flagged file_start; records carry blue and
// red swapped out of stored order, rows come in stored order (no vertical flip),
// and a run packet yields one record with its repeat count.
`default_nettype none
module tga_rle_image_decoder (
   input wire logic      clock,
   input wire logic      reset,
   tgadec_req_if.sink    req_chan,
   tgadec_rsp_if.source  rsp_chan
);

   logic                rsp_valid_ff, rsp_valid_in;
   tgadec_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic                accept;
   logic                res_valid;
   tgadec_pkg::rsp_type res;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   tgadec_core u_core (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .byte_value (req_chan.byte_value),
      .file_start (req_chan.file_start),
      .res_valid  (res_valid),
      .res        (res)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      if (accept && res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.red          = rsp_data_ff.red;
   assign rsp_chan.green        = rsp_data_ff.green;
   assign rsp_chan.blue         = rsp_data_ff.blue;
   assign rsp_chan.alpha        = rsp_data_ff.alpha;
   assign rsp_chan.has_alpha    = rsp_data_ff.has_alpha;
   assign rsp_chan.repeat_count = rsp_data_ff.repeat_count;
   assign rsp_chan.image_done   = rsp_data_ff.image_done;
   assign rsp_chan.status       = rsp_data_ff.status;

   a_hold_intake: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |-> !req_chan.ready)
      else $error("byte intake open while a result is held");

   a_error_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.status == tgadec_pkg::ST_BAD_SIG ||
                         rsp_chan.status == tgadec_pkg::ST_BAD_SIZE)
      |-> rsp_chan.repeat_count == 8'd0 && !rsp_chan.image_done)
      else $error("status-only result carries pixel data");

   a_clip_done: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status == tgadec_pkg::ST_CLIPPED |-> rsp_chan.image_done)
      else $error("clipped record does not complete the image");

   a_pixel_count: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status == tgadec_pkg::ST_OK
      |-> rsp_chan.repeat_count != 8'd0)
      else $error("pixel record with zero repeat count");

endmodule
`default_nettype wire
